// File: src/cprbp_pkg.sv
package cprbp_pkg;

   localparam int POOL_SLOTS = 16;
   localparam int SLOT_W     = 4;
   localparam int CLASS_W    = 2;
   localparam int REFS_W     = 8;
   localparam int COUNT_W    = 4;
   localparam int START_W    = 5;

   localparam logic [REFS_W-1:0]  REFS_MAX  = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_ADD_REF = 2'd2,
      MODE_CLEAR   = 2'd3
   } cprbp_mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_NOT_ALLOC = 2'd2,
      STATUS_SATURATED = 2'd3
   } cprbp_status_type;

   // Classified command handed from front to back.
   typedef struct packed {
      cprbp_mode_type          mode;
      logic [CLASS_W-1:0]      cls;        // size_class, or class of slot
      logic [SLOT_W-1:0]       slot;
      logic                    in_pool;    // slot lies inside some class range
      logic [POOL_SLOTS-1:0]   alloc_mask; // slots of the requested class
   } cprbp_cmd_type;

   function automatic int cprbp_clip(input int v);
      return (v > POOL_SLOTS) ? POOL_SLOTS : v;
   endfunction

endpackage

// File: src/cprbp_front.sv
module cprbp_front #(
   parameter int BASIC_SLOTS    = 8,
   parameter int DATAGRAM_SLOTS = 4,
   parameter int SNIP_SLOTS     = 2,
   parameter int STREAM_SLOTS   = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_mode,
   input  logic [cprbp_pkg::CLASS_W-1:0] req_size_class,
   input  logic [cprbp_pkg::SLOT_W-1:0]  req_slot_index,
   output logic                          cmd_valid,
   output cprbp_pkg::cprbp_cmd_type      cmd,
   input  logic                          cmd_take
);
   import cprbp_pkg::*;

   localparam int S1 = cprbp_clip(BASIC_SLOTS);
   localparam int S2 = cprbp_clip(BASIC_SLOTS + DATAGRAM_SLOTS);
   localparam int S3 = cprbp_clip(BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS);
   localparam int S4 = cprbp_clip(BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS + STREAM_SLOTS);

   localparam logic [START_W-1:0] CLASS_LO [4] =
      '{5'd0, START_W'(S1), START_W'(S2), START_W'(S3)};
   localparam logic [START_W-1:0] CLASS_HI [4] =
      '{START_W'(S1), START_W'(S2), START_W'(S3), START_W'(S4)};

   localparam int DEPTH = 2;

   cprbp_cmd_type          entry_ff [DEPTH];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   cprbp_cmd_type          decoded;
   logic [START_W-1:0]     slot_ext;
   logic                   push_ok;

   // classify: class ranges for allocate, owning class for free / add-ref
   always_comb begin
      slot_ext         = {1'b0, req_slot_index};
      decoded.mode     = cprbp_mode_type'(req_mode);
      decoded.slot     = req_slot_index;
      decoded.in_pool  = slot_ext < CLASS_HI[3];
      for (int s = 0; s < POOL_SLOTS; s++) begin
         decoded.alloc_mask[s] = (START_W'(s) >= CLASS_LO[req_size_class]) &&
                                 (START_W'(s) <  CLASS_HI[req_size_class]);
      end
      if ((decoded.mode == MODE_ALLOC) || (decoded.mode == MODE_CLEAR)) begin
         decoded.cls = req_size_class;
      end else if (!decoded.in_pool) begin
         decoded.cls = 2'd0;
      end else if (slot_ext >= CLASS_LO[3]) begin
         decoded.cls = 2'd3;
      end else if (slot_ext >= CLASS_LO[2]) begin
         decoded.cls = 2'd2;
      end else if (slot_ext >= CLASS_LO[1]) begin
         decoded.cls = 2'd1;
      end else begin
         decoded.cls = 2'd0;
      end
   end

   assign req_full  = (count_ff == 2'(DEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: src/cprbp_back.sv
module cprbp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  cprbp_pkg::cprbp_cmd_type      cmd,
   output logic                          cmd_take,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_status,
   output logic [cprbp_pkg::SLOT_W-1:0]  rsp_granted_slot,
   output logic [cprbp_pkg::CLASS_W-1:0] rsp_slot_class,
   output logic [cprbp_pkg::REFS_W-1:0]  rsp_refs_after,
   output logic [cprbp_pkg::COUNT_W-1:0] rsp_class_in_use,
   output logic [cprbp_pkg::COUNT_W-1:0] rsp_class_high_water
);
   import cprbp_pkg::*;

   logic [POOL_SLOTS-1:0] busy_ff, busy_in;
   logic [REFS_W-1:0]     refs_ff   [POOL_SLOTS];
   logic [REFS_W-1:0]     refs_in   [POOL_SLOTS];
   logic [COUNT_W-1:0]    in_use_ff [4];
   logic [COUNT_W-1:0]    in_use_in [4];
   logic [COUNT_W-1:0]    peak_ff   [4];
   logic [COUNT_W-1:0]    peak_in   [4];
   logic                  valid_ff;

   cprbp_status_type      status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CLASS_W-1:0]    cls_ff;
   logic [REFS_W-1:0]     refs_out_ff, refs_out_in;
   logic [COUNT_W-1:0]    use_out_ff, peak_out_ff;

   logic [POOL_SLOTS-1:0] free_mask;
   logic                  found;
   logic [SLOT_W-1:0]     pick;
   logic [REFS_W-1:0]     cur_refs;

   // results sit in one output register; next command goes in when it drains
   assign cmd_take  = cmd_valid && (!valid_ff || rsp_pop);
   assign free_mask = cmd.alloc_mask & ~busy_ff;
   assign cur_refs  = refs_ff[cmd.slot];

   // lowest free slot of the class
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
         if (free_mask[s]) begin
            found = 1'b1;
            pick  = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      refs_in     = refs_ff;
      in_use_in   = in_use_ff;
      peak_in     = peak_ff;
      status_in   = STATUS_OK;
      slot_in     = cmd.slot;
      refs_out_in = '0;
      unique case (cmd.mode)
         MODE_ALLOC: begin
            if (found) begin
               busy_in[pick] = 1'b1;
               refs_in[pick] = 8'd1;
               if (in_use_ff[cmd.cls] < COUNT_MAX) begin
                  in_use_in[cmd.cls] = in_use_ff[cmd.cls] + 4'd1;
               end
               if (in_use_in[cmd.cls] > peak_ff[cmd.cls]) begin
                  peak_in[cmd.cls] = in_use_in[cmd.cls];
               end
               slot_in     = pick;
               refs_out_in = 8'd1;
            end else begin
               status_in = STATUS_NO_FREE;
               slot_in   = '0;
            end
         end
         MODE_CLEAR: begin
            for (int c = 0; c < 4; c++) begin
               peak_in[c] = '0;
            end
            slot_in = '0;
         end
         MODE_FREE: begin
            if (!cmd.in_pool || !busy_ff[cmd.slot]) begin
               status_in = STATUS_NOT_ALLOC;
            end else if (cur_refs > 8'd1) begin
               refs_in[cmd.slot] = cur_refs - 8'd1;
               refs_out_in       = cur_refs - 8'd1;
            end else begin
               refs_in[cmd.slot] = '0;
               busy_in[cmd.slot] = 1'b0;
               if (in_use_ff[cmd.cls] != '0) begin
                  in_use_in[cmd.cls] = in_use_ff[cmd.cls] - 4'd1;
               end
            end
         end
         MODE_ADD_REF: begin
            if (!cmd.in_pool || !busy_ff[cmd.slot]) begin
               status_in = STATUS_NOT_ALLOC;
            end else if (cur_refs == REFS_MAX) begin
               status_in   = STATUS_SATURATED;
               refs_out_in = REFS_MAX;
            end else begin
               refs_in[cmd.slot] = cur_refs + 8'd1;
               refs_out_in       = cur_refs + 8'd1;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= '0;
         for (int s = 0; s < POOL_SLOTS; s++) begin
            refs_ff[s] <= '0;
         end
         for (int c = 0; c < 4; c++) begin
            in_use_ff[c] <= '0;
            peak_ff[c]   <= '0;
         end
      end else begin
         if (cmd_take) begin
            valid_ff  <= 1'b1;
            busy_ff   <= busy_in;
            refs_ff   <= refs_in;
            in_use_ff <= in_use_in;
            peak_ff   <= peak_in;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         status_ff   <= status_in;
         slot_ff     <= slot_in;
         cls_ff      <= cmd.cls;
         refs_out_ff <= refs_out_in;
         use_out_ff  <= in_use_in[cmd.cls];
         peak_out_ff <= peak_in[cmd.cls];
      end
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_granted_slot     = slot_ff;
   assign rsp_slot_class       = cls_ff;
   assign rsp_refs_after       = refs_out_ff;
   assign rsp_class_in_use     = use_out_ff;
   assign rsp_class_high_water = peak_out_ff;

endmodule

// File: src/class_partitioned_refcount_buffer_pool.sv
// A pushed beat goes into the command queue, then the output register behind rsp_.
// Throughput: one beat per cycle while results are popped; the back end runs
//   each command combinationally against the slot and class state.
// Two-entry command queue between front and back; one output register.
// Reset (synchronous, active high): all slots free, all counts zero, both queues empty.
module class_partitioned_refcount_buffer_pool #(
   parameter int BASIC_SLOTS    = 8,
   parameter int DATAGRAM_SLOTS = 4,
   parameter int SNIP_SLOTS     = 2,
   parameter int STREAM_SLOTS   = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_mode,
   input  logic [cprbp_pkg::CLASS_W-1:0] req_size_class,
   input  logic [cprbp_pkg::SLOT_W-1:0]  req_slot_index,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_status,
   output logic [cprbp_pkg::SLOT_W-1:0]  rsp_granted_slot,
   output logic [cprbp_pkg::CLASS_W-1:0] rsp_slot_class,
   output logic [cprbp_pkg::REFS_W-1:0]  rsp_refs_after,
   output logic [cprbp_pkg::COUNT_W-1:0] rsp_class_in_use,
   output logic [cprbp_pkg::COUNT_W-1:0] rsp_class_high_water
);
   import cprbp_pkg::*;

   // front -> back command channel
   logic          cmd_valid;
   logic          cmd_take;
   cprbp_cmd_type cmd;

   // Front: classifies each beat (class range for allocate, requested class for clear,
   // owning class of the slot for free / add-ref) and queues it.
   cprbp_front #(
      .BASIC_SLOTS    (BASIC_SLOTS),
      .DATAGRAM_SLOTS (DATAGRAM_SLOTS),
      .SNIP_SLOTS     (SNIP_SLOTS),
      .STREAM_SLOTS   (STREAM_SLOTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_size_class (req_size_class),
      .req_slot_index (req_slot_index),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   // Back: owns busy bits, ref counts, in-use and high-water counters;
   // executes one command per cycle when the output register is free.
   cprbp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd),
      .cmd_take             (cmd_take),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_status           (rsp_status),
      .rsp_granted_slot     (rsp_granted_slot),
      .rsp_slot_class       (rsp_slot_class),
      .rsp_refs_after       (rsp_refs_after),
      .rsp_class_in_use     (rsp_class_in_use),
      .rsp_class_high_water (rsp_class_high_water)
   );

endmodule

// File: src/cprbp_checker.sv
module cprbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [1:0]                    rsp_status,
   input logic [cprbp_pkg::SLOT_W-1:0]  rsp_granted_slot,
   input logic [cprbp_pkg::REFS_W-1:0]  rsp_refs_after
);
   import cprbp_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_no_free_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_NO_FREE) |->
         (rsp_granted_slot == '0 && rsp_refs_after == '0))
      else $error("no-free result carries slot or refs");

   a_not_alloc_refs: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_NOT_ALLOC) |-> (rsp_refs_after == '0))
      else $error("not-allocated result carries refs");

   a_saturated_refs: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_SATURATED) |-> (rsp_refs_after == REFS_MAX))
      else $error("saturated result without full count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_status) && $stable(rsp_granted_slot)
          && $stable(rsp_refs_after)))
      else $error("waiting result changed");

endmodule

bind class_partitioned_refcount_buffer_pool cprbp_checker u_cprbp_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the class-partitioned, reference-counted buffer pool.
// Command beats go in through the req_ queue port. Response beats come out
// through the rsp_ queue port. A behavioral pool model runs alongside the
// block. Every accepted command beat is applied to the model at once, so the
// queue of due responses always reflects accept order. Each popped response
// beat is checked field by field against the oldest due entry.
module testbench;
   import cprbp_pkg::*;

   // Pool layout; passed to the block so the model and RTL agree.
   localparam int N_BASIC    = 8;
   localparam int N_DATAGRAM = 4;
   localparam int N_SNIP     = 2;
   localparam int N_STREAM   = 2;

   localparam int HOLD_CYCLES  = 200;     // long receiver hold-off for the backpressure test
   localparam int DRAIN_CYCLES = 10;      // settle time after the last response
   localparam int CYCLE_LIMIT  = 400000;  // watchdog limit on simulated cycles
   localparam int RANDOM_BEATS = 150;

   typedef struct {
      cprbp_status_type     status;
      logic [SLOT_W-1:0]    slot;
      logic [CLASS_W-1:0]   cls;
      logic [REFS_W-1:0]    refs;
      logic [COUNT_W-1:0]   in_use;
      logic [COUNT_W-1:0]   peak;
   } pool_answer_type;

   // DUT ports; every input has a known value from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [1:0]           req_mode = MODE_ALLOC;
   logic [CLASS_W-1:0]   req_size_class = '0;
   logic [SLOT_W-1:0]    req_slot_index = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [1:0]           rsp_status;
   logic [SLOT_W-1:0]    rsp_granted_slot;
   logic [CLASS_W-1:0]   rsp_slot_class;
   logic [REFS_W-1:0]    rsp_refs_after;
   logic [COUNT_W-1:0]   rsp_class_in_use;
   logic [COUNT_W-1:0]   rsp_class_high_water;

   // Pool model state
   logic                 pool_busy  [POOL_SLOTS] = '{default: 1'b0};
   logic [REFS_W-1:0]    pool_refs  [POOL_SLOTS] = '{default: '0};
   logic [COUNT_W-1:0]   class_used [4]          = '{default: '0};
   logic [COUNT_W-1:0]   class_peak [4]          = '{default: '0};

   pool_answer_type      answers_due [$];   // responses owed by the block, oldest first
   pool_answer_type      last_due;          // model answer for the most recent command beat

   // Bookkeeping
   int                   mismatches      = 0;
   int                   beats_sent      = 0;
   int                   results_checked = 0;
   int                   status_seen [4] = '{default: 0};
   int                   full_stalls     = 0;
   int                   cycle_count     = 0;

   // Sender and receiver idling controls
   bit                   tx_idle   = 1'b1;
   bit                   rx_idle   = 1'b1;
   bit                   hold_req  = 1'b0;
   int                   hold_left = 0;
   int                   holds_done = 0;
   int                   pop_wait  = 0;
   int                   rx_phase  = 0;

   class_partitioned_refcount_buffer_pool #(
      .BASIC_SLOTS    (N_BASIC),
      .DATAGRAM_SLOTS (N_DATAGRAM),
      .SNIP_SLOTS     (N_SNIP),
      .STREAM_SLOTS   (N_STREAM)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_mode             (req_mode),
      .req_size_class       (req_size_class),
      .req_slot_index       (req_slot_index),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_status           (rsp_status),
      .rsp_granted_slot     (rsp_granted_slot),
      .rsp_slot_class       (rsp_slot_class),
      .rsp_refs_after       (rsp_refs_after),
      .rsp_class_in_use     (rsp_class_in_use),
      .rsp_class_high_water (rsp_class_high_water)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Pool model
   // ------------------------------------------------------------------

   // First slot of class c; c = 4 is the end of the pool. Ranges are laid
   // out back to back and cut off at the pool size.
   function automatic int class_base(input int c);
      int sum;
      sum = 0;
      if (c > 0) sum += N_BASIC;
      if (c > 1) sum += N_DATAGRAM;
      if (c > 2) sum += N_SNIP;
      if (c > 3) sum += N_STREAM;
      return (sum > POOL_SLOTS) ? POOL_SLOTS : sum;
   endfunction

   // Owning class of a slot; 4 means the slot lies past every range.
   function automatic int owner_class(input int s);
      for (int c = 0; c < 4; c++)
         if (s >= class_base(c) && s < class_base(c + 1)) return c;
      return 4;
   endfunction

   function automatic pool_answer_type make_answer(input cprbp_status_type st, input int slot,
                                                   input int cls, input int refs);
      pool_answer_type a;
      a.status = st;
      a.slot   = SLOT_W'(slot);
      a.cls    = CLASS_W'(cls);
      a.refs   = REFS_W'(refs);
      a.in_use = class_used[cls];
      a.peak   = class_peak[cls];
      return a;
   endfunction

   // Applies one command to the pool model and returns the response it owes.
   function automatic pool_answer_type compute_pool_answer(input cprbp_mode_type mode,
                                                           input int cls, input int slot);
      int owner;
      if (mode == MODE_ALLOC) begin
         // lowest free slot in the class range wins
         for (int s = class_base(cls); s < class_base(cls + 1); s++) begin
            if (!pool_busy[s]) begin
               pool_busy[s] = 1'b1;
               pool_refs[s] = 1;
               if (class_used[cls] < COUNT_MAX) class_used[cls]++;
               if (class_used[cls] > class_peak[cls]) class_peak[cls] = class_used[cls];
               return make_answer(STATUS_OK, s, cls, 1);
            end
         end
         return make_answer(STATUS_NO_FREE, 0, cls, 0);
      end
      if (mode == MODE_CLEAR) begin
         for (int c = 0; c < 4; c++) class_peak[c] = '0;
         return make_answer(STATUS_OK, 0, cls, 0);
      end
      // free / add reference: bad slots are refused and change nothing
      owner = owner_class(slot);
      if (owner > 3 || !pool_busy[slot])
         return make_answer(STATUS_NOT_ALLOC, slot, (owner > 3) ? 0 : owner, 0);
      if (mode == MODE_FREE) begin
         if (pool_refs[slot] > 1) begin
            pool_refs[slot]--;
         end else begin
            pool_refs[slot] = '0;
            pool_busy[slot] = 1'b0;
            if (class_used[owner] > 0) class_used[owner]--;
         end
         return make_answer(STATUS_OK, slot, owner, pool_refs[slot]);
      end
      if (pool_refs[slot] == REFS_MAX) return make_answer(STATUS_SATURATED, slot, owner, REFS_MAX);
      pool_refs[slot]++;
      return make_answer(STATUS_OK, slot, owner, pool_refs[slot]);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus plumbing
   // ------------------------------------------------------------------

   // Idle length: mostly none or short, now and then a long gap.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one command beat and waits for the block to take it. Called at a
   // rising edge; push only drops when a gap is inserted, so it never gets
   // two updates in one step.
   task automatic send_beat(input cprbp_mode_type mode, input int cls, input int slot);
      int gap;
      gap = tx_idle ? idle_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_mode       <= mode;
      req_size_class <= CLASS_W'(cls);
      req_slot_index <= SLOT_W'(slot);
      do @(posedge clock); while (req_full !== 1'b0);
      last_due = compute_pool_answer(mode, cls, slot);
      answers_due.push_back(last_due);
      beats_sent++;
   endtask

   // Random command; free and add-reference mostly hit live slots so
   // refcounts climb and slots get released, the rest are stray targets.
   task automatic send_random_beat(input int alloc_pct);
      int held [$];
      int r;
      int slot;
      cprbp_mode_type mode;
      for (int s = 0; s < POOL_SLOTS; s++)
         if (pool_busy[s]) held.push_back(s);
      slot = $urandom_range(0, POOL_SLOTS - 1);
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
         mode = MODE_ALLOC;
      end else begin
         r = $urandom_range(0, 99);
         mode = (r < 8) ? MODE_CLEAR : (r < 65) ? MODE_FREE : MODE_ADD_REF;
         if (held.size() > 0 && $urandom_range(0, 99) < 80)
            slot = held[$urandom_range(0, held.size() - 1)];
      end
      send_beat(mode, $urandom_range(0, 3), slot);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked walk: class full, release at zero, stray free/ref,
   // reuse of a freed slot, clears, slot 0 and slot 15.
   task automatic test_directed();
      int dg;
      int sn;
      int st;
      dg = class_base(1);
      sn = class_base(2);
      st = class_base(3);
      send_beat(MODE_ALLOC,   3, 0);
      send_beat(MODE_ALLOC,   3, 0);
      send_beat(MODE_ALLOC,   3, 0);          // stream class now full
      send_beat(MODE_ALLOC,   0, 0);
      send_beat(MODE_ALLOC,   1, 0);
      send_beat(MODE_ALLOC,   2, 0);
      send_beat(MODE_ADD_REF, 0, 0);
      send_beat(MODE_FREE,    0, 0);
      send_beat(MODE_FREE,    0, 0);          // count hits zero, slot released
      send_beat(MODE_FREE,    0, 0);          // already free
      send_beat(MODE_ADD_REF, 3, 0);          // ref on a free slot
      send_beat(MODE_FREE,    2, POOL_SLOTS - 1);
      send_beat(MODE_ADD_REF, 1, st);
      send_beat(MODE_ALLOC,   3, 15);         // refills the slot just freed
      send_beat(MODE_CLEAR,   3, 0);
      send_beat(MODE_CLEAR,   0, 15);
      send_beat(MODE_ADD_REF, 0, dg + 1);     // datagram slot never allocated
      send_beat(MODE_FREE,    3, st);
      send_beat(MODE_FREE,    3, st);
      send_beat(MODE_FREE,    0, POOL_SLOTS - 1);
      send_beat(MODE_FREE,    1, dg);
      send_beat(MODE_FREE,    2, sn);
   endtask

   // Every class to full and one more, then free everything in random order.
   task automatic test_fill_and_drain();
      int held [$];
      int k;
      for (int c = 0; c < 4; c++) begin
         repeat (class_base(c + 1) - class_base(c) + 1)
            send_beat(MODE_ALLOC, c, $urandom_range(0, POOL_SLOTS - 1));
         if (c == 1) send_beat(MODE_CLEAR, $urandom_range(0, 3), 0);
      end
      for (int s = 0; s < POOL_SLOTS; s++)
         if (pool_busy[s]) held.push_back(s);
      while (held.size() > 0) begin
         k = $urandom_range(0, held.size() - 1);
         send_beat(MODE_FREE, $urandom_range(0, 3), held[k]);
         held.delete(k);
      end
   endtask

   // Drive one slot's count to 255, past it twice, then all the way back.
   task automatic test_refcount_saturation();
      int slot;
      tx_idle = 1'b0;
      send_beat(MODE_ALLOC, 1, 0);
      slot = last_due.slot;
      repeat (int'(REFS_MAX) + 1) send_beat(MODE_ADD_REF, $urandom_range(0, 3), slot);
      repeat (int'(REFS_MAX) + 1) send_beat(MODE_FREE, $urandom_range(0, 3), slot);
      tx_idle = 1'b1;
   endtask

   // Receiver stops popping for a long stretch while the sender keeps
   // offering back-to-back beats, so the block fills and raises req_full.
   task automatic test_backpressure();
      hold_req = 1'b1;
      tx_idle  = 1'b0;
      repeat (24) send_random_beat(50);
      tx_idle  = 1'b1;
   endtask

   // Random traffic in phases that alternate between allocate-heavy and
   // release-heavy, so classes swing between full and empty.
   task automatic test_random_traffic();
      int alloc_pct;
      alloc_pct = 60;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 50 == 0) begin
            alloc_pct = ((n / 50) % 2 != 0) ? 20 : 60;
            tx_idle   = ($urandom_range(0, 3) != 0);
         end
         send_random_beat(alloc_pct);
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver, checker, watchdog
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at response %0d: %s", results_checked, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // Pop driver: a requested hold-off runs to completion, counted here;
   // otherwise random pauses, with calm stretches now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
         holds_done++;
         rsp_pop <= 1'b0;
      end else if (pop_wait > 0) begin
         pop_wait--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         pop_wait = rx_idle ? idle_gap() : 0;
      end
      rx_phase++;
      if (rx_phase % 256 == 0) rx_idle = ($urandom_range(0, 3) != 0);
   end

   // Response check: sampled at the edge, so values are the ones the beat
   // was accepted with.
   always @(posedge clock) begin
      pool_answer_type want;
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response beat with nothing outstanding");
         end else begin
            want = answers_due.pop_front();
            check_field("status",           rsp_status,           want.status);
            check_field("granted_slot",     rsp_granted_slot,     want.slot);
            check_field("slot_class",       rsp_slot_class,       want.cls);
            check_field("refs_after",       rsp_refs_after,       want.refs);
            check_field("class_in_use",     rsp_class_in_use,     want.in_use);
            check_field("class_high_water", rsp_class_high_water, want.peak);
            status_seen[want.status]++;
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_push && req_full === 1'b1) full_stalls++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, answers_due.size());
         $display("[class_partitioned_refcount_buffer_pool] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_refcount_saturation();
      test_backpressure();
      test_random_traffic();
      req_push <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d command beats, checked %0d responses: %0d ok, %0d pool full, %0d bad slot",
               beats_sent, results_checked, status_seen[STATUS_OK], status_seen[STATUS_NO_FREE],
               status_seen[STATUS_NOT_ALLOC]);
      $display("%0d refcount saturations, %0d receiver hold-offs, %0d cycles with input stalled",
               status_seen[STATUS_SATURATED], holds_done, full_stalls);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("[class_partitioned_refcount_buffer_pool] OK");
      end else begin
         $display("[class_partitioned_refcount_buffer_pool] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/cprbp_pkg.sv
src/cprbp_front.sv
src/cprbp_back.sv
src/class_partitioned_refcount_buffer_pool.sv
src/cprbp_checker.sv
dv/testbench.sv
